@@ hdl/rbs_pkg.sv @@
`timescale 1ns / 1ps
// package for the ray / box slab test
// default widths shared by the interfaces and the top level, no dependencies
package rbs_pkg;
  localparam int COORD_WIDTH_DEF   = 32;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int NUM_AXES          = 3;
  localparam int NUM_LANES         = 2 * NUM_AXES;
endpackage

@@ hdl/rbs_if.sv @@
`timescale 1ns / 1ps
// valid/ready channel interfaces for the ray / box slab test
// depends on rbs_pkg for the default coordinate width
interface rbs_req_if #(parameter int CW = rbs_pkg::COORD_WIDTH_DEF) ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] origin_x;
  logic signed [CW-1:0] origin_y;
  logic signed [CW-1:0] origin_z;
  logic signed [CW-1:0] dir_x;
  logic signed [CW-1:0] dir_y;
  logic signed [CW-1:0] dir_z;
  logic signed [CW-1:0] box_min_x;
  logic signed [CW-1:0] box_min_y;
  logic signed [CW-1:0] box_min_z;
  logic signed [CW-1:0] box_max_x;
  logic signed [CW-1:0] box_max_y;
  logic signed [CW-1:0] box_max_z;
  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
                  input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
                output ready);
endinterface

interface rbs_rsp_if #(parameter int CW = rbs_pkg::COORD_WIDTH_DEF) ();
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic signed [CW-1:0] t_enter;
  logic signed [CW-1:0] t_exit;
  modport source (output valid, hit, t_enter, t_exit, input ready);
  modport sink (input valid, hit, t_enter, t_exit, output ready);
endinterface

@@ hdl/ray_box_slab_test.sv @@
`timescale 1ns / 1ps
// ray against axis-aligned box, slab test, fully pipelined
// depends on rbs_pkg and the channel interfaces in rbs_if.sv
//
//   channel  dir  payload
//   req      in   origin_x..z, dir_x..z, box_min_x..z, box_max_x..z
//   rsp      out  hit, t_enter, t_exit
//
// one transaction per cycle unless the output stalls; registers in order: prep,
// the six restoring dividers (Q16.16 by default), saturate, order, reduce, output;
// one quotient bit per stage over COORD_WIDTH + 1 + FRACTION_BITS stages.
// rst clears the valid bits only. a stalled output freezes the whole pipeline,
// so nothing is dropped or repeated; req.ready is low only while rsp is held.
module ray_box_slab_test #(
  parameter int COORD_WIDTH   = rbs_pkg::COORD_WIDTH_DEF,
  parameter int FRACTION_BITS = rbs_pkg::FRACTION_BITS_DEF
) (
  input logic     clk,
  input logic     rst,
  rbs_req_if.sink req,
  rbs_rsp_if.source rsp
);
  import rbs_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int NW = CW + 1 + FRACTION_BITS;
  localparam logic [CW-1:0] LIM_POS = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] LIM_NEG = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    logic [NW-1:0] num;
    logic [CW-1:0] den;
    logic [CW-1:0] rem;
    logic [CW-1:0] quo;
    logic          big;
    logic          neg;
  } lane_t;

  typedef struct packed {
    logic dz;
    logic below;
    logic above;
  } axf_t;

  function automatic lane_t div_step(input lane_t x);
    logic [CW:0] rs;
    lane_t       y;
    rs = {x.rem, x.num[NW-1]};
    y = x;
    y.num = {x.num[NW-2:0], 1'b0};
    y.big = x.big | x.quo[CW-1];
    if (rs >= {1'b0, x.den}) begin
      y.rem = CW'(rs - {1'b0, x.den});
      y.quo = {x.quo[CW-2:0], 1'b1};
    end else begin
      y.rem = rs[CW-1:0];
      y.quo = {x.quo[CW-2:0], 1'b0};
    end
    return y;
  endfunction

  function automatic logic signed [CW-1:0] smax(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic signed [CW-1:0] smin(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  logic en;

  // input gather
  logic signed [CW-1:0] org [NUM_AXES];
  logic signed [CW-1:0] dir [NUM_AXES];
  logic signed [CW-1:0] bmin [NUM_AXES];
  logic signed [CW-1:0] bmax [NUM_AXES];

  assign org[0]  = req.origin_x;
  assign org[1]  = req.origin_y;
  assign org[2]  = req.origin_z;
  assign dir[0]  = req.dir_x;
  assign dir[1]  = req.dir_y;
  assign dir[2]  = req.dir_z;
  assign bmin[0] = req.box_min_x;
  assign bmin[1] = req.box_min_y;
  assign bmin[2] = req.box_min_z;
  assign bmax[0] = req.box_max_x;
  assign bmax[1] = req.box_max_y;
  assign bmax[2] = req.box_max_z;

  // divider pipeline: stage 0 is the prep register
  lane_t dv     [NW+1][NUM_LANES];
  axf_t  dv_axf [NW+1][NUM_AXES];
  logic  dv_vld [NW+1];

  lane_t prep     [NUM_LANES];
  axf_t  prep_axf [NUM_AXES];

  always_comb begin
    logic signed [CW:0] diff;
    logic signed [CW-1:0] corner;
    for (int a = 0; a < NUM_AXES; a++) begin
      prep_axf[a].dz    = (dir[a] == '0);
      prep_axf[a].below = (org[a] < bmin[a]);
      prep_axf[a].above = (org[a] > bmax[a]);
      for (int c = 0; c < 2; c++) begin
        corner = (c == 0) ? bmin[a] : bmax[a];
        diff = $signed({corner[CW-1], corner}) - $signed({org[a][CW-1], org[a]});
        prep[2*a+c].num = {(diff[CW] ? (CW+1)'(-diff) : (CW+1)'(diff)),
                           {FRACTION_BITS{1'b0}}};
        prep[2*a+c].den = dir[a][CW-1] ? CW'(-dir[a]) : CW'(dir[a]);
        prep[2*a+c].rem = '0;
        prep[2*a+c].quo = '0;
        prep[2*a+c].big = 1'b0;
        prep[2*a+c].neg = diff[CW] ^ dir[a][CW-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0]     <= prep;
      dv_axf[0] <= prep_axf;
      for (int s = 0; s < NW; s++) begin
        for (int l = 0; l < NUM_LANES; l++) begin
          dv[s+1][l] <= div_step(dv[s][l]);
        end
        dv_axf[s+1] <= dv_axf[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= NW; s++) dv_vld[s] <= 1'b0;
    end else if (en) begin
      dv_vld[0] <= req.valid;
      for (int s = 0; s < NW; s++) dv_vld[s+1] <= dv_vld[s];
    end
  end

  // saturate and sign the quotients
  logic signed [CW-1:0] fin_t   [NUM_LANES];
  axf_t                 fin_axf [NUM_AXES];
  logic                 fin_vld;

  always_ff @(posedge clk) begin
    logic [CW-1:0] lim;
    logic [CW-1:0] qs;
    if (en) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        lim = dv[NW][l].neg ? LIM_NEG : LIM_POS;
        qs  = (dv[NW][l].big || dv[NW][l].quo > lim) ? lim : dv[NW][l].quo;
        fin_t[l] <= dv[NW][l].neg ? $signed(CW'(-qs)) : $signed(qs);
      end
      fin_axf <= dv_axf[NW];
    end
  end

  // order each slab, zero direction overrides
  logic signed [CW-1:0] ord_tn [NUM_AXES];
  logic signed [CW-1:0] ord_tf [NUM_AXES];
  logic                 ord_miss;
  logic                 ord_vld;

  always_ff @(posedge clk) begin
    logic m;
    if (en) begin
      m = 1'b0;
      for (int a = 0; a < NUM_AXES; a++) begin
        if (fin_axf[a].dz) begin
          if (fin_axf[a].below) begin
            ord_tn[a] <= $signed(LIM_POS);
            ord_tf[a] <= $signed(LIM_POS);
            m = 1'b1;
          end else if (fin_axf[a].above) begin
            ord_tn[a] <= $signed(LIM_NEG);
            ord_tf[a] <= $signed(LIM_NEG);
            m = 1'b1;
          end else begin
            ord_tn[a] <= $signed(LIM_NEG);
            ord_tf[a] <= $signed(LIM_POS);
          end
        end else begin
          ord_tn[a] <= smin(fin_t[2*a], fin_t[2*a+1]);
          ord_tf[a] <= smax(fin_t[2*a], fin_t[2*a+1]);
        end
      end
      ord_miss <= m;
    end
  end

  // reduce over the axes
  logic signed [CW-1:0] red_enter;
  logic signed [CW-1:0] red_exit;
  logic                 red_miss;
  logic                 red_vld;

  always_ff @(posedge clk) begin
    if (en) begin
      red_enter <= smax(smax(ord_tn[0], ord_tn[1]), ord_tn[2]);
      red_exit  <= smin(smin(ord_tf[0], ord_tf[1]), ord_tf[2]);
      red_miss  <= ord_miss;
    end
  end

  // output register
  logic                 out_vld;
  logic                 out_hit;
  logic signed [CW-1:0] out_enter;
  logic signed [CW-1:0] out_exit;

  always_ff @(posedge clk) begin
    if (en) begin
      out_hit   <= !red_miss && (red_exit >= red_enter) && !red_exit[CW-1];
      out_enter <= red_enter;
      out_exit  <= red_exit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_vld <= 1'b0;
      ord_vld <= 1'b0;
      red_vld <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      fin_vld <= dv_vld[NW];
      ord_vld <= fin_vld;
      red_vld <= ord_vld;
      out_vld <= red_vld;
    end
  end

  assign en          = !out_vld || rsp.ready;
  assign req.ready   = en;
  assign rsp.valid   = out_vld;
  assign rsp.hit     = out_hit;
  assign rsp.t_enter = out_enter;
  assign rsp.t_exit  = out_exit;

  // a reported hit must be consistent with its distances
  a_hit_order: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.hit |-> (rsp.t_exit >= rsp.t_enter) && !rsp.t_exit[CW-1])
    else $error("hit reported with exit before entry or behind origin");

  // a frozen pipeline keeps its occupancy
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(red_vld) && $stable(ord_vld) && $stable(fin_vld))
    else $error("pipeline valid bits moved during a stall");

  // a finished lane-0 divider result with a nonzero axis-0 direction never comes from a zero divisor
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    dv_vld[NW] && !dv_axf[NW][0].dz |-> dv[NW][0].den != '0)
    else $error("divider lane ran with zero divisor");
endmodule

@@ dv/ray_box_slab_test_tb.sv @@
`timescale 1ns / 1ps
// testbench for the ray / box slab test: directed table, then random rays
// depends on rbs_pkg, rbs_if.sv and ray_box_slab_test.sv
module ray_box_slab_test_tb;
  import rbs_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int FB = FRACTION_BITS_DEF;
  localparam int LATENCY = CW + FB + 5;
  localparam int N_RANDOM = 930;
  localparam longint CYCLE_LIMIT = 400000;
  localparam logic signed [CW-1:0] DIST_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] DIST_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] ONE = 1 <<< FB;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    coord_t org [3];
    coord_t dir [3];
    coord_t lo [3];
    coord_t hi [3];
  } ray_box_t;

  typedef struct packed {
    logic   hit;
    coord_t t_enter;
    coord_t t_exit;
  } crossing_t;

  typedef struct {
    ray_box_t  ray;
    logic      typed;   // expected result given in the row
    crossing_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  longint cycles = 0;
  int errors = 0;
  logic sender_idle_ok = 1'b1;
  logic receiver_idle_ok = 1'b1;

  crossing_t expected_crossings [$];
  ray_box_t  ray_queue [$];
  stim_row_t table_rows [$];

  rbs_req_if #(.CW(CW)) req ();
  rbs_rsp_if #(.CW(CW)) rsp ();

  ray_box_slab_test #(.COORD_WIDTH(CW), .FRACTION_BITS(FB)) uut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // signed (num << FB) / den, truncated toward zero, saturated
  function automatic coord_t slab_distance(input logic signed [CW:0] num, input coord_t den);
    logic signed [CW+FB+2:0] q;
    q = ($signed({{(FB+2){num[CW]}}, num}) <<< FB) / den;
    if (q > DIST_MAX) return DIST_MAX;
    if (q < DIST_MIN) return DIST_MIN;
    return q[CW-1:0];
  endfunction

  function automatic crossing_t predict_crossing(input ray_box_t r);
    crossing_t c;
    coord_t near_t, far_t, t0, t1;
    logic missed;
    missed = 1'b0;
    c.t_enter = DIST_MIN;
    c.t_exit = DIST_MAX;
    for (int a = 0; a < 3; a++) begin
      if (r.dir[a] == 0) begin
        if (r.org[a] < r.lo[a]) begin
          near_t = DIST_MAX; far_t = DIST_MAX; missed = 1'b1;
        end else if (r.org[a] > r.hi[a]) begin
          near_t = DIST_MIN; far_t = DIST_MIN; missed = 1'b1;
        end else begin
          near_t = DIST_MIN; far_t = DIST_MAX;
        end
      end else begin
        t0 = slab_distance({r.lo[a][CW-1], r.lo[a]} - {r.org[a][CW-1], r.org[a]}, r.dir[a]);
        t1 = slab_distance({r.hi[a][CW-1], r.hi[a]} - {r.org[a][CW-1], r.org[a]}, r.dir[a]);
        near_t = (t0 < t1) ? t0 : t1;
        far_t = (t0 < t1) ? t1 : t0;
      end
      if (near_t > c.t_enter) c.t_enter = near_t;
      if (far_t < c.t_exit) c.t_exit = far_t;
    end
    c.hit = !missed && c.t_exit >= c.t_enter && c.t_exit >= 0;
    return c;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(0, 20 * 65536)) - 10 * 65536);
      2: return $urandom_range(0, 1) ? DIST_MAX : DIST_MIN;
      3: return coord_t'($signed($urandom_range(0, 400)) - 200);
      default: return coord_t'($signed($urandom_range(0, 200 * 65536)) - 100 * 65536);
    endcase
  endfunction

  // mostly a box around a target, ray aimed roughly at it; sometimes noise
  function automatic ray_box_t rand_ray();
    ray_box_t r;
    coord_t c, h;
    bit aimed;
    aimed = $urandom_range(0, 3) != 0;
    for (int a = 0; a < 3; a++) begin
      if (aimed) begin
        c = coord_t'($signed($urandom_range(0, 40 * 65536)) - 20 * 65536);
        h = coord_t'($urandom_range(0, 4 * 65536));
        r.lo[a] = c - h;
        r.hi[a] = c + h;
        if ($urandom_range(0, 15) == 0) begin
          r.lo[a] = c + h; r.hi[a] = c - h;
        end
        r.org[a] = coord_t'($signed($urandom_range(0, 60 * 65536)) - 30 * 65536);
        r.dir[a] = (c - r.org[a]) >>> $urandom_range(0, 6);
        if ($urandom_range(0, 9) == 0) r.dir[a] = 0;
        if ($urandom_range(0, 9) == 0) r.dir[a] = rand_coord();
      end else begin
        r.org[a] = rand_coord(); r.dir[a] = rand_coord();
        r.lo[a] = rand_coord(); r.hi[a] = rand_coord();
        if ($urandom_range(0, 7) == 0) r.dir[a] = 0;
      end
    end
    return r;
  endfunction

  function automatic ray_box_t make_ray(input coord_t o, input coord_t d,
                                        input coord_t l, input coord_t h);
    ray_box_t r;
    for (int a = 0; a < 3; a++) begin
      r.org[a] = o; r.dir[a] = d; r.lo[a] = l; r.hi[a] = h;
    end
    return r;
  endfunction

  task automatic add_row(input ray_box_t r, input logic typed, input logic hit,
                         input coord_t te, input coord_t tx);
    stim_row_t s;
    s.ray = r; s.typed = typed;
    s.want.hit = hit; s.want.t_enter = te; s.want.t_exit = tx;
    table_rows = {table_rows, s};
  endtask

  task automatic build_table();
    ray_box_t r;
    // zero direction, origin inside on every axis: unbounded
    add_row(make_ray(0, 0, -ONE, ONE), 1'b1, 1'b1, DIST_MIN, DIST_MAX);
    // zero direction, origin on the bounds
    add_row(make_ray(ONE, 0, -ONE, ONE), 1'b1, 1'b1, DIST_MIN, DIST_MAX);
    add_row(make_ray(-ONE, 0, -ONE, ONE), 1'b1, 1'b1, DIST_MIN, DIST_MAX);
    // zero direction, origin below / above the slab
    add_row(make_ray(-2 * ONE, 0, -ONE, ONE), 1'b1, 1'b0, DIST_MAX, DIST_MAX);
    add_row(make_ray(2 * ONE, 0, -ONE, ONE), 1'b1, 1'b0, DIST_MIN, DIST_MIN);
    // zero direction, reversed corners
    add_row(make_ray(0, 0, ONE, -ONE), 1'b0, 1'b0, 0, 0);
    // unit direction, box 1..2 ahead
    add_row(make_ray(0, ONE, ONE, 2 * ONE), 1'b1, 1'b1, ONE, 2 * ONE);
    // box behind the ray
    add_row(make_ray(0, ONE, -2 * ONE, -ONE), 1'b1, 1'b0, -2 * ONE, -ONE);
    // negative direction, reversed corners
    add_row(make_ray(0, -ONE, -ONE, -2 * ONE), 1'b1, 1'b1, ONE, 2 * ONE);
    // extreme distances saturate
    add_row(make_ray(DIST_MIN, 1, DIST_MAX, DIST_MAX), 1'b1, 1'b1, DIST_MAX, DIST_MAX);
    add_row(make_ray(DIST_MAX, 1, DIST_MIN, DIST_MIN), 1'b1, 1'b0, DIST_MIN, DIST_MIN);
    add_row(make_ray(DIST_MAX, DIST_MIN, DIST_MIN, DIST_MAX), 1'b0, 1'b0, 0, 0);
    add_row(make_ray(DIST_MIN, DIST_MAX, DIST_MIN, DIST_MAX), 1'b0, 1'b0, 0, 0);
    add_row(make_ray(-1, -1, DIST_MIN, DIST_MAX), 1'b0, 1'b0, 0, 0);
    add_row(make_ray(DIST_MAX, DIST_MAX, DIST_MAX, DIST_MAX), 1'b0, 1'b0, 0, 0);
    add_row(make_ray(DIST_MIN, DIST_MIN, DIST_MIN, DIST_MIN), 1'b0, 1'b0, 0, 0);
    add_row(make_ray(-1, -1, -1, -1), 1'b0, 1'b0, 0, 0);
    add_row(make_ray(0, 3, 1, 7), 1'b0, 1'b0, 0, 0);
    // mixed axes: one zero-direction miss with the others hitting, then one axis with a smaller negative direction
    r = make_ray(0, ONE, ONE, 2 * ONE);
    r.dir[1] = 0; r.org[1] = 5 * ONE;
    add_row(r, 1'b0, 1'b0, 0, 0);
    r = make_ray(0, ONE, -ONE, 3 * ONE);
    r.dir[2] = -ONE >>> 2;
    add_row(r, 1'b0, 1'b0, 0, 0);
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_ray(input ray_box_t r);
    while (sender_idle_ok && $urandom_range(0, 99) < 14) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid <= 1'b1;
    req.origin_x <= r.org[0]; req.origin_y <= r.org[1]; req.origin_z <= r.org[2];
    req.dir_x <= r.dir[0]; req.dir_y <= r.dir[1]; req.dir_z <= r.dir[2];
    req.box_min_x <= r.lo[0]; req.box_min_y <= r.lo[1]; req.box_min_z <= r.lo[2];
    req.box_max_x <= r.hi[0]; req.box_max_y <= r.hi[1]; req.box_max_z <= r.hi[2];
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // capture accepted rays at the edge and queue their predictions; check each response against the oldest one
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && req.valid && req.ready)
      expected_crossings = {expected_crossings, predict_crossing(ray_queue.pop_front())};
    if (!rst && rsp.valid && rsp.ready) begin
      crossing_t w;
      if (expected_crossings.size() == 0) begin
        report_mismatch("unexpected transaction", 1, 0);
      end else begin
        w = expected_crossings.pop_front();
        if (rsp.hit !== w.hit) report_mismatch("hit", rsp.hit, w.hit);
        if (rsp.t_enter !== w.t_enter) report_mismatch("t_enter", rsp.t_enter, w.t_enter);
        if (rsp.t_exit !== w.t_exit) report_mismatch("t_exit", rsp.t_exit, w.t_exit);
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout");
      $display("FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    rsp.ready <= !(receiver_idle_ok && $urandom_range(0, 99) < 14);
  end

  initial begin
    ray_box_t r;
    crossing_t p;
    req.valid = 1'b0;
    {req.origin_x, req.origin_y, req.origin_z} = '0;
    {req.dir_x, req.dir_y, req.dir_z} = '0;
    {req.box_min_x, req.box_min_y, req.box_min_z} = '0;
    {req.box_max_x, req.box_max_y, req.box_max_z} = '0;
    rsp.ready = 1'b0;
    build_table();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (table_rows[i]) begin
      if (table_rows[i].typed) begin
        p = predict_crossing(table_rows[i].ray);
        if (p != table_rows[i].want) report_mismatch("table row", i, i);
      end
      ray_queue = {ray_queue, table_rows[i].ray};
      send_ray(table_rows[i].ray);
    end

    // drain fully before the random part
    req.valid <= 1'b0;
    while (expected_crossings.size() != 0) @(negedge clk);

    for (int n = 0; n < N_RANDOM; n++) begin
      // stretch with no idling on either side
      sender_idle_ok <= !(n >= 300 && n < 450);
      receiver_idle_ok <= !(n >= 300 && n < 450);
      if (n == 600) begin
        req.valid <= 1'b0;
        @(negedge clk);
        while (expected_crossings.size() != 0) @(negedge clk);
      end
      r = rand_ray();
      ray_queue = {ray_queue, r};
      send_ray(r);
    end

    req.valid <= 1'b0;
    while (expected_crossings.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
